// ----- rtl/core/smps_pkg.sv -----
// ----------------------------------------------------------------------------
// smps_pkg
// Shared types, widths and constants for the stepper move pulse spreader.
// ----------------------------------------------------------------------------
package smps_pkg;

    // Field widths
    localparam int unsigned APP_W   = 24;
    localparam int unsigned DUR_W   = 16;
    localparam int unsigned ANGLE_W = 24;
    localparam int unsigned POS_W   = 32;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned ERR_W   = 33;

    // Reset value of the angle-per-pulse register (Q8.16 degrees)
    localparam logic [APP_W-1:0] APP_RESET = 24'd7373;

    // Default timer tick rate
    localparam int unsigned TICKS_PER_SECOND_DEF = 10000;

    // Current angle product: signed position times unsigned step angle
    localparam int unsigned PROD_W = POS_W + APP_W + 1;
    // Signed distance, one bit wider than the product
    localparam int unsigned DIFF_W = PROD_W + 1;
    // Rounding numerator 2*|dist| + app, and divisor 2*app
    localparam int unsigned NUM_W  = DIFF_W;
    localparam int unsigned DEN_W  = APP_W + 1;
    // Two quotient bits per divider step
    localparam int unsigned DIV_STEPS = NUM_W / 2;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    // Input item
    typedef struct packed {
        logic                      kind;
        logic [DUR_W-1:0]          duration_seconds;
        logic signed [ANGLE_W-1:0] target_angle;
    } smps_in_t;

    // Result item
    typedef struct packed {
        logic                    step_pulse;
        logic                    direction;
        logic                    busy_res;
        logic                    move_done;
        logic                    rejected;
        logic signed [POS_W-1:0] position;
    } smps_out_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_WAIT,
        ST_MUL,
        ST_DIFF,
        ST_NUM,
        ST_DIV,
        ST_SETUP,
        ST_TADD,
        ST_TSUB,
        ST_TCHK,
        ST_REPORT
    } smps_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic mul;
        logic diff;
        logic num;
        logic div_step;
        logic setup;
        logic tadd;
        logic tsub;
        logic tchk;
        logic load_out;
    } smps_ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic moving;
        logic div_last;
        logic out_free;
    } smps_sts_t;

endpackage

// ----- rtl/core/smps_if.sv -----
// ----------------------------------------------------------------------------
// smps_if
// Valid/ready stream interfaces for the command and result channels.
// ----------------------------------------------------------------------------
interface smps_cmd_if;
    import smps_pkg::*;

    logic     valid;
    logic     ready;
    smps_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface smps_res_if;
    import smps_pkg::*;

    logic      valid;
    logic      ready;
    smps_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/smps_ctrl.sv -----
// ----------------------------------------------------------------------------
// smps_ctrl
// Sequencer: walks each item through move set-up or tick update, then
// hands the result to the output register.
// ----------------------------------------------------------------------------
module smps_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  logic                cmd_kind,
    output logic                cmd_ready,
    input  smps_pkg::smps_sts_t sts,
    output smps_pkg::smps_ctl_t ctl
);
    import smps_pkg::*;

    smps_state_t state_reg;
    smps_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_WAIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_WAIT:
            begin
                if (cmd_valid)
                begin
                    if (cmd_kind && !sts.moving)
                    begin
                        state_next = ST_MUL;
                    end
                    else if (!cmd_kind && sts.moving)
                    begin
                        state_next = ST_TADD;
                    end
                    else
                    begin
                        // idle tick or rejected move: report straight away
                        state_next = ST_REPORT;
                    end
                end
            end
            ST_MUL:    state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_NUM;
            ST_NUM:    state_next = ST_DIV;
            ST_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:  state_next = ST_REPORT;
            ST_TADD:   state_next = ST_TSUB;
            ST_TSUB:   state_next = ST_TCHK;
            ST_TCHK:   state_next = ST_REPORT;
            ST_REPORT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_WAIT;
                end
            end
            default:   state_next = ST_WAIT;
        endcase
    end

    // Outputs
    always_comb
    begin
        ctl       = '0;
        cmd_ready = 1'b0;
        case (state_reg)
            ST_WAIT:
            begin
                cmd_ready   = 1'b1;
                ctl.capture = cmd_valid;
            end
            ST_MUL:    ctl.mul      = 1'b1;
            ST_DIFF:   ctl.diff     = 1'b1;
            ST_NUM:    ctl.num      = 1'b1;
            ST_DIV:    ctl.div_step = 1'b1;
            ST_SETUP:  ctl.setup    = 1'b1;
            ST_TADD:   ctl.tadd     = 1'b1;
            ST_TSUB:   ctl.tsub     = 1'b1;
            ST_TCHK:   ctl.tchk     = 1'b1;
            ST_REPORT: ctl.load_out = sts.out_free;
            default:   ctl          = '0;
        endcase
    end

endmodule

// ----- rtl/core/smps_dp.sv -----
// ----------------------------------------------------------------------------
// smps_dp
// Datapath: step angle register, move set-up arithmetic with a radix-4
// restoring divider, Bresenham error term, position and output register.
// ----------------------------------------------------------------------------
module smps_dp
#(
    parameter int unsigned TICKS_PER_SECOND = smps_pkg::TICKS_PER_SECOND_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [smps_pkg::APP_W-1:0]  cfg_wdata,
    input  smps_pkg::smps_in_t          in_data,
    input  smps_pkg::smps_ctl_t         ctl,
    output smps_pkg::smps_sts_t         sts,
    input  logic                        res_ready,
    output logic                        res_valid,
    output smps_pkg::smps_out_t         res_data
);
    import smps_pkg::*;

    localparam int unsigned TPS_W      = $clog2(TICKS_PER_SECOND + 1);
    localparam int unsigned SPAN_EXT_W = DUR_W + TPS_W + CNT_W;
    localparam logic [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};

    // Registers
    logic [APP_W-1:0]        app_reg,    app_next;
    logic [DUR_W-1:0]        dur_reg,    dur_next;
    logic [ANGLE_W-1:0]      tgt_reg,    tgt_next;
    logic signed [PROD_W-1:0] prod_reg,  prod_next;
    logic [DIFF_W-1:0]       diff_reg,   diff_next;
    logic [NUM_W-1:0]        num_reg,    num_next;
    logic [DEN_W-1:0]        den_reg,    den_next;
    logic [DEN_W-1:0]        rem_reg,    rem_next;
    logic [CNT_W-1:0]        q_reg,      q_next;
    logic                    ovf_reg,    ovf_next;
    logic [DIV_CNT_W-1:0]    divc_reg,   divc_next;
    logic [CNT_W-1:0]        span_reg,   span_next;
    logic [CNT_W-1:0]        pt_reg,     pt_next;
    logic [CNT_W-1:0]        pdone_reg,  pdone_next;
    logic [ERR_W-1:0]        err_reg,    err_next;
    logic [POS_W-1:0]        pos_reg,    pos_next;
    logic                    rev_reg,    rev_next;
    logic                    moving_reg, moving_next;
    logic                    pulse_reg,  pulse_next;
    logic                    done_reg,   done_next;
    logic                    rej_reg,    rej_next;
    logic                    rvalid_reg, rvalid_next;
    smps_out_t               rdata_reg,  rdata_next;

    // Combinational helpers
    logic [APP_W-1:0]        app_eff;
    logic [SPAN_EXT_W-1:0]   span_ext;
    logic [DIFF_W-1:0]       tgt_ext;
    logic [NUM_W-1:0]        diff2;
    logic [NUM_W-1:0]        app_num;
    logic [DEN_W:0]          t1, t2;
    logic                    b1, b0;
    logic [DEN_W-1:0]        r1, r2;
    logic [ERR_W:0]          err_sum;
    logic                    err_pos;

    // Zero step angle behaves as one
    assign app_eff = (app_reg == '0) ? APP_W'(1) : app_reg;

    // Tick span product, saturated to the counter width
    assign span_ext = SPAN_EXT_W'(dur_reg) * SPAN_EXT_W'(TICKS_PER_SECOND);

    // Target in Q.16, sign extended to the distance width
    assign tgt_ext = {{(DIFF_W-ANGLE_W-8){tgt_reg[ANGLE_W-1]}}, tgt_reg, 8'h00};

    // Rounding numerator terms
    assign diff2   = {diff_reg[NUM_W-2:0], 1'b0};
    assign app_num = NUM_W'(den_reg[DEN_W-1:1]);

    // Divider: two restoring steps per cycle
    assign t1 = {rem_reg, num_reg[NUM_W-1]};
    assign b1 = (t1 >= {1'b0, den_reg});
    assign r1 = b1 ? DEN_W'(t1 - {1'b0, den_reg}) : t1[DEN_W-1:0];
    assign t2 = {r1, num_reg[NUM_W-2]};
    assign b0 = (t2 >= {1'b0, den_reg});
    assign r2 = b0 ? DEN_W'(t2 - {1'b0, den_reg}) : t2[DEN_W-1:0];

    // Error term update, clamped at the top of the signed range
    assign err_sum = {err_reg[ERR_W-1], err_reg} + {2'b00, pt_reg};
    assign err_pos = !err_reg[ERR_W-1] && (err_reg != '0);

    // Next-state logic
    always_comb
    begin
        app_next    = app_reg;
        dur_next    = dur_reg;
        tgt_next    = tgt_reg;
        prod_next   = prod_reg;
        diff_next   = diff_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        ovf_next    = ovf_reg;
        divc_next   = divc_reg;
        span_next   = span_reg;
        pt_next     = pt_reg;
        pdone_next  = pdone_reg;
        err_next    = err_reg;
        pos_next    = pos_reg;
        rev_next    = rev_reg;
        moving_next = moving_reg;
        pulse_next  = pulse_reg;
        done_next   = done_reg;
        rej_next    = rej_reg;
        rdata_next  = rdata_reg;
        rvalid_next = rvalid_reg;

        if (cfg_we)
        begin
            app_next = cfg_wdata;
        end

        // Take in the item; a move while busy is flagged here
        if (ctl.capture)
        begin
            dur_next   = in_data.duration_seconds;
            tgt_next   = in_data.target_angle;
            pulse_next = 1'b0;
            done_next  = 1'b0;
            rej_next   = in_data.kind && moving_reg;
        end

        // Current angle, divisor and tick span
        if (ctl.mul)
        begin
            prod_next = $signed(pos_reg) * $signed({1'b0, app_eff});
            den_next  = {app_eff, 1'b0};
            span_next = (|span_ext[SPAN_EXT_W-1:CNT_W]) ? '1 : span_ext[CNT_W-1:0];
        end

        // Signed distance and direction
        if (ctl.diff)
        begin
            diff_next = DIFF_W'($signed({prod_reg[PROD_W-1], prod_reg}) - $signed(tgt_ext));
            rev_next  = !diff_next[DIFF_W-1];
        end

        // Numerator 2*|dist| + app, divider start
        if (ctl.num)
        begin
            num_next  = rev_reg ? (diff2 + app_num) : (app_num - diff2);
            rem_next  = '0;
            q_next    = '0;
            ovf_next  = 1'b0;
            divc_next = '0;
        end

        if (ctl.div_step)
        begin
            num_next  = {num_reg[NUM_W-3:0], 2'b00};
            rem_next  = r2;
            q_next    = {q_reg[CNT_W-3:0], b1, b0};
            ovf_next  = ovf_reg || (|q_reg[CNT_W-1:CNT_W-2]);
            divc_next = divc_reg + DIV_CNT_W'(1);
        end

        // Load the move
        if (ctl.setup)
        begin
            pt_next     = ovf_reg ? '1 : q_reg;
            err_next    = ERR_W'(0) - {2'b00, span_reg[CNT_W-1:1]};
            pdone_next  = '0;
            moving_next = 1'b1;
        end

        if (ctl.tadd)
        begin
            err_next = (err_sum[ERR_W:ERR_W-1] == 2'b01) ? ERR_MAX : err_sum[ERR_W-1:0];
        end

        // Emit a pulse when the error goes positive
        if (ctl.tsub && err_pos)
        begin
            pulse_next = 1'b1;
            pdone_next = pdone_reg + CNT_W'(1);
            pos_next   = rev_reg ? (pos_reg - POS_W'(1)) : (pos_reg + POS_W'(1));
            err_next   = err_reg - {1'b0, span_reg};
        end

        if (ctl.tchk && (pdone_reg == pt_reg))
        begin
            moving_next = 1'b0;
            done_next   = 1'b1;
        end

        // Output register
        if (ctl.load_out)
        begin
            rdata_next.step_pulse = pulse_reg;
            rdata_next.direction  = rev_reg;
            rdata_next.busy_res   = moving_reg;
            rdata_next.move_done  = done_reg;
            rdata_next.rejected   = rej_reg;
            rdata_next.position   = pos_reg;
            rvalid_next           = 1'b1;
        end
        else if (res_ready)
        begin
            rvalid_next = 1'b0;
        end
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            app_reg    <= APP_RESET;
            divc_reg   <= '0;
            span_reg   <= '0;
            pt_reg     <= '0;
            pdone_reg  <= '0;
            err_reg    <= '0;
            pos_reg    <= '0;
            rev_reg    <= 1'b0;
            moving_reg <= 1'b0;
            pulse_reg  <= 1'b0;
            done_reg   <= 1'b0;
            rej_reg    <= 1'b0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            app_reg    <= app_next;
            divc_reg   <= divc_next;
            span_reg   <= span_next;
            pt_reg     <= pt_next;
            pdone_reg  <= pdone_next;
            err_reg    <= err_next;
            pos_reg    <= pos_next;
            rev_reg    <= rev_next;
            moving_reg <= moving_next;
            pulse_reg  <= pulse_next;
            done_reg   <= done_next;
            rej_reg    <= rej_next;
            rvalid_reg <= rvalid_next;
        end
    end

    // Working registers, no reset
    always_ff @(posedge clk)
    begin
        dur_reg   <= dur_next;
        tgt_reg   <= tgt_next;
        prod_reg  <= prod_next;
        diff_reg  <= diff_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        ovf_reg   <= ovf_next;
        rdata_reg <= rdata_next;
    end

    // Status and outputs
    assign sts.moving   = moving_reg;
    assign sts.div_last = (divc_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign sts.out_free = !rvalid_reg || res_ready;
    assign res_valid    = rvalid_reg;
    assign res_data     = rdata_reg;

endmodule

// ----- rtl/core/stepper_move_pulse_spreader_core.sv -----
// ----------------------------------------------------------------------------
// stepper_move_pulse_spreader_core
// Move commands set up a pulse count and direction; timer ticks spread the
// step pulses evenly over the move with a Bresenham error term.
// ----------------------------------------------------------------------------
// One item is worked on at a time and every item gives one result. A timer
// tick during a move passes through accept, error add, error subtract and
// step, completion check and result load. An idle tick or a rejected move goes
// from accept to result load. A move command passes through multiply,
// distance, numerator, the 29-step radix-4 divider that rounds distance over
// angle per pulse to a pulse count, and set-up. The result sits in an output
// register, so the next item is accepted while it waits to be taken; an item
// only stalls if the previous result is still held when its own is ready.
// ----------------------------------------------------------------------------
module stepper_move_pulse_spreader_core
#(
    parameter int unsigned TICKS_PER_SECOND = smps_pkg::TICKS_PER_SECOND_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [smps_pkg::APP_W-1:0] cfg_wdata,
    smps_cmd_if.sink                   cmd,
    smps_res_if.source                 res
);
    import smps_pkg::*;

    smps_ctl_t ctl;
    smps_sts_t sts;

    // Sequencer
    smps_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_kind  (cmd.data.kind),
        .cmd_ready (cmd.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    // Arithmetic and state
    smps_dp
    #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (cmd.data),
        .ctl       (ctl),
        .sts       (sts),
        .res_ready (res.ready),
        .res_valid (res.valid),
        .res_data  (res.data)
    );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stepper move pulse spreader. Move commands and
// timer ticks are sent over the command stream with random idle gaps. The
// result stream is stalled at random. Each transfer is checked against a
// cycle-free model of the block: pulse count rounding, direction, Bresenham
// spreading and busy, done and refusal flags. The step angle register is
// swept through zero, one, full scale and random settings between phases.
// ----------------------------------------------------------------------------
module testbench;
    import smps_pkg::*;

    localparam int unsigned TICKS_PER_SEC = TICKS_PER_SECOND_DEF;
    localparam longint      ERR_HI        = 64'sd4294967295;
    localparam longint      ERR_LO        = -64'sd4294967296;
    localparam longint      ANGLE_HI      = 64'sd8388607;
    localparam longint      ANGLE_LO      = -64'sd8388608;
    localparam bit          KIND_TICK     = 1'b0;
    localparam bit          KIND_MOVE     = 1'b1;
    localparam int          REPORT_MAX    = 10;

    // ------------------------------------------------------------------------
    // Step scoreboard: predicts each result from accepted commands and checks
    // results in order
    // ------------------------------------------------------------------------
    class step_scoreboard;
        logic [APP_W-1:0] step_angle;
        logic [POS_W-1:0] position;
        longint           err_acc;
        logic [CNT_W-1:0] tick_span;
        logic [CNT_W-1:0] pulse_goal;
        logic [CNT_W-1:0] pulse_count;
        bit               reverse;
        bit               moving;
        smps_out_t        expected_steps[$];
        int               mismatches;
        int               checked;
        int               commands;
        int               pulses;
        int               moves_done;
        int               refusals;

        function new();
            step_angle  = APP_RESET;
            position    = '0;
            err_acc     = 0;
            tick_span   = '0;
            pulse_goal  = '0;
            pulse_count = '0;
            reverse     = 1'b0;
            moving      = 1'b0;
            mismatches  = 0;
            checked     = 0;
            commands    = 0;
            pulses      = 0;
            moves_done  = 0;
            refusals    = 0;
        endfunction

        static function longint clamp_err(longint v);
            if (v > ERR_HI)
                return ERR_HI;
            if (v < ERR_LO)
                return ERR_LO;
            return v;
        endfunction

        // Work out the result of one accepted command
        function void note_command(smps_in_t it);
            smps_out_t       r;
            longint unsigned app;
            longint unsigned dist_q16;
            longint unsigned quot;
            longint unsigned ticks;
            longint          pos_s;
            longint          ang_s;
            longint          cur;
            longint          tgt;

            r = '0;
            commands++;
            if (it.kind == KIND_MOVE)
            begin
                if (moving)
                begin
                    r.rejected = 1'b1;
                    refusals++;
                end
                else
                begin
                    // zero step angle behaves as one
                    app   = (step_angle == '0) ? 64'd1 : longint'(step_angle);
                    pos_s = $signed(position);
                    ang_s = $signed(it.target_angle);
                    cur   = pos_s * longint'(app);
                    tgt   = ang_s * 256;
                    if (cur >= tgt)
                    begin
                        reverse  = 1'b1;
                        dist_q16 = cur - tgt;
                    end
                    else
                    begin
                        reverse  = 1'b0;
                        dist_q16 = tgt - cur;
                    end
                    // round to nearest, halves upwards
                    quot       = (2 * dist_q16 + app) / (2 * app);
                    pulse_goal = (quot > 64'hFFFF_FFFF) ? '1 : quot[CNT_W-1:0];
                    ticks      = longint'(it.duration_seconds) * longint'(TICKS_PER_SEC);
                    tick_span  = (ticks > 64'hFFFF_FFFF) ? '1 : ticks[CNT_W-1:0];
                    err_acc    = -longint'(tick_span >> 1);
                    pulse_count = '0;
                    moving      = 1'b1;
                end
            end
            else if (moving)
            begin
                err_acc = clamp_err(err_acc + longint'(pulse_goal));
                if (err_acc > 0)
                begin
                    r.step_pulse = 1'b1;
                    pulses++;
                    pulse_count = pulse_count + 1'b1;
                    position    = reverse ? position - 1'b1 : position + 1'b1;
                    err_acc     = clamp_err(err_acc - longint'(tick_span));
                end
                if (pulse_count == pulse_goal)
                begin
                    moving      = 1'b0;
                    r.move_done = 1'b1;
                    moves_done++;
                end
            end
            r.direction = reverse;
            r.busy_res  = moving;
            r.position  = position;
            expected_steps.push_back(r);
        endfunction

        // Compare one result transfer with the oldest prediction
        function void check_result(smps_out_t got);
            smps_out_t exp_r;

            if (expected_steps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display({"%0t: result with nothing pending: ",
                              "pulse %0b dir %0b busy %0b done %0b rej %0b pos %0d"},
                             $realtime, got.step_pulse, got.direction, got.busy_res,
                             got.move_done, got.rejected, got.position);
                return;
            end
            exp_r = expected_steps.pop_front();
            checked++;
            if (got.step_pulse != exp_r.step_pulse || got.direction != exp_r.direction ||
                got.busy_res != exp_r.busy_res || got.move_done != exp_r.move_done ||
                got.rejected != exp_r.rejected || got.position != exp_r.position)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $display("%0t: result %0d differs", $realtime, checked);
                    $display("  expected: pulse %0b dir %0b busy %0b done %0b rej %0b pos %0d",
                             exp_r.step_pulse, exp_r.direction, exp_r.busy_res,
                             exp_r.move_done, exp_r.rejected, exp_r.position);
                    $display("  actual:   pulse %0b dir %0b busy %0b done %0b rej %0b pos %0d",
                             got.step_pulse, got.direction, got.busy_res,
                             got.move_done, got.rejected, got.position);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, channels and block under test
    // ------------------------------------------------------------------------
    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [APP_W-1:0] cfg_wdata;
    bit               send_quiet;
    bit               recv_quiet;
    int               settings_used;
    step_scoreboard   sb;

    smps_cmd_if cmd_ch ();
    smps_res_if res_ch ();

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    stepper_move_pulse_spreader_core #(
        .TICKS_PER_SECOND (TICKS_PER_SEC)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_ch),
        .res       (res_ch)
    );

    // ------------------------------------------------------------------------
    // Driving tasks; each returns in the time step of a rising edge
    // ------------------------------------------------------------------------
    function automatic smps_in_t cmd_item(bit kind, logic [DUR_W-1:0] dur,
                                          logic [ANGLE_W-1:0] angle);
        smps_in_t it;

        it.kind             = kind;
        it.duration_seconds = dur;
        it.target_angle     = angle;
        return it;
    endfunction

    // One command transfer, after a random idle gap
    task automatic send_command(smps_in_t it);
        int gap;

        if ($urandom_range(0, 39) == 0)
            send_quiet = !send_quiet;
        gap = send_quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= it;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        sb.note_command(it);
    endtask

    // Hold off until every predicted result has been taken
    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.expected_steps.size() != 0);
    endtask

    // Register write; only called with the block drained
    task automatic write_step_angle(logic [APP_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we        <= 1'b0;
        sb.step_angle  = value;
        settings_used++;
    endtask

    // Move to roughly goal_pos steps, with sub-step noise in the target angle
    task automatic send_move_to(longint goal_pos, logic [DUR_W-1:0] dur);
        longint app;
        longint tq;
        longint ang;

        app = (sb.step_angle == '0) ? 1 : longint'(sb.step_angle);
        tq  = goal_pos * app + longint'($urandom_range(0, app)) - app / 2;
        ang = tq >>> 8;
        if (ang > ANGLE_HI)
            ang = ANGLE_HI;
        if (ang < ANGLE_LO)
            ang = ANGLE_LO;
        send_command(cmd_item(KIND_MOVE, dur, ang[ANGLE_W-1:0]));
    endtask

    task automatic tick_until_idle();
        while (sb.moving)
            send_command(cmd_item(KIND_TICK, '0, '0));
    endtask

    // Mostly short well-formed moves, with refused moves and idle ticks mixed in
    task automatic run_random(int n_items);
        int     done_items;
        longint pos_now;
        longint goal;

        done_items = 0;
        while (done_items < n_items)
        begin
            if ($urandom_range(0, 149) == 0)
                drain_results();
            if (!sb.moving)
            begin
                if ($urandom_range(0, 6) == 0)
                begin
                    send_command(cmd_item(KIND_TICK, DUR_W'($urandom), ANGLE_W'($urandom)));
                end
                else
                begin
                    pos_now = $signed(sb.position);
                    if ($urandom_range(0, 3) == 0)
                        goal = longint'($urandom_range(0, 80)) - 40;
                    else
                        goal = pos_now + longint'($urandom_range(0, 12)) - 6;
                    if (goal > 60)
                        goal = 60;
                    if (goal < -60)
                        goal = -60;
                    send_move_to(goal, '0);
                    done_items++;
                end
            end
            else
            begin
                if ($urandom_range(0, 9) == 0)
                    send_command(cmd_item(KIND_MOVE, DUR_W'($urandom), ANGLE_W'($urandom)));
                else if ($urandom_range(0, 1) == 0)
                    send_command(cmd_item(KIND_TICK, DUR_W'($urandom), ANGLE_W'($urandom)));
                else
                    send_command(cmd_item(KIND_TICK, '0, '0));
                done_items++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls on ready, checking on every transfer
    // ------------------------------------------------------------------------
    initial
    begin
        int gap;

        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                recv_quiet = !recv_quiet;
            gap = recv_quiet ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(res_ch.valid && res_ch.ready));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            sb.check_result(res_ch.data);
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int     i;
        longint off;

        sb            = new();
        send_quiet    = 1'b0;
        recv_quiet    = 1'b0;
        settings_used = 1;
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= '0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset step angle: idle ticks, a zero-pulse move, short moves both
        // ways and moves refused while busy
        send_command(cmd_item(KIND_TICK, '0, '0));
        send_command(cmd_item(KIND_TICK, '1, '1));
        send_command(cmd_item(KIND_MOVE, '0, '0));
        send_command(cmd_item(KIND_TICK, '0, '0));
        send_command(cmd_item(KIND_MOVE, '0, 24'd86));
        send_command(cmd_item(KIND_MOVE, '1, 24'h800000));
        repeat (3) send_command(cmd_item(KIND_TICK, '0, '0));
        send_command(cmd_item(KIND_TICK, '0, '0));
        send_command(cmd_item(KIND_MOVE, '0, '0));
        send_command(cmd_item(KIND_MOVE, 16'h5555, 24'h7FFFFF));
        repeat (3) send_command(cmd_item(KIND_TICK, '0, '0));
        drain_results();

        // Full-scale step angle with the extreme target angles
        write_step_angle('1);
        send_command(cmd_item(KIND_MOVE, '0, 24'h7FFFFF));
        tick_until_idle();
        send_command(cmd_item(KIND_MOVE, '0, 24'h800000));
        tick_until_idle();
        drain_results();

        // Random phases over a spread of step angle settings
        write_step_angle('0);
        run_random(160);
        drain_results();
        write_step_angle(24'd1);
        run_random(160);
        drain_results();
        write_step_angle(APP_W'($urandom_range(2, 255)));
        run_random(160);
        drain_results();
        write_step_angle(APP_W'($urandom_range(256, 65535)));
        run_random(160);
        drain_results();
        write_step_angle(APP_RESET);
        run_random(160);
        drain_results();
        write_step_angle(APP_W'($urandom_range(1, 16777215)));
        run_random(160);
        drain_results();
        write_step_angle('1);
        run_random(160);
        drain_results();
        tick_until_idle();
        drain_results();

        // One-second move: pulses spread with gaps over the tick span; the
        // opening ticks are checked, a move in the middle is refused and the
        // move is still running when the run ends
        write_step_angle(APP_RESET);
        off = longint'($urandom_range(200, 9000));
        if ($urandom_range(0, 1) == 0)
            off = -off;
        send_move_to(longint'($signed(sb.position)) + off, 16'd1);
        for (i = 0; i < 300; i++)
        begin
            if (i == 150)
                send_command(cmd_item(KIND_MOVE, '1, 24'h7FFFFF));
            else
                send_command(cmd_item(KIND_TICK, '0, '0));
        end
        drain_results();
        repeat (40) @(posedge clk);

        sb.mismatches += sb.expected_steps.size();
        $display("Run covered %0d commands and %0d checked results over %0d step angle settings",
                 sb.commands, sb.checked, settings_used);
        $display("Step pulses %0d, completed moves %0d, refused moves %0d",
                 sb.pulses, sb.moves_done, sb.refusals);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog
    initial
    begin
        #40_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
